>>> hw/rtl/owrr_pkg.sv
// Package: shared types and constants of the 1-Wire read-ROM master.
`timescale 1ns / 1ps
package owrr_pkg;

  // Sequencer phases
  typedef enum logic [2:0] {
    PH_IDLE     = 3'd0,
    PH_RST_LOW  = 3'd1,
    PH_RST_WAIT = 3'd2,
    PH_RST_REC  = 3'd3,
    PH_WRITE    = 3'd4,
    PH_READ     = 3'd5
  } phase_e;

  // Result status codes
  localparam logic [1:0] StNone      = 2'd0;
  localparam logic [1:0] StKeyByte   = 2'd1;
  localparam logic [1:0] StNoPresent = 2'd2;
  localparam logic [1:0] StRefused   = 2'd3;

  // Input op codes
  localparam logic OpTick  = 1'b0;
  localparam logic OpStart = 1'b1;

  // Register addresses (word index)
  localparam logic RegEnabled = 1'b0;

  // Bus timing in microseconds
  localparam logic [8:0] RstLowUs     = 9'd480;
  localparam logic [8:0] PresSampleUs = 9'd70;
  localparam logic [8:0] RstRecUs     = 9'd410;
  localparam logic [8:0] Wr1LowUs     = 9'd5;
  localparam logic [8:0] Wr1SlotUs    = 9'd60;
  localparam logic [8:0] Wr0LowUs     = 9'd60;
  localparam logic [8:0] Wr0SlotUs    = 9'd65;
  localparam logic [8:0] RdLowUs      = 9'd2;
  localparam logic [8:0] RdSampleUs   = 9'd12;
  localparam logic [8:0] RdSlotUs     = 9'd62;

  // Read ROM command, sent LSB first
  localparam logic [7:0] RomCmd = 8'h33;

  // Number of ROM bytes read per sequence
  localparam logic [3:0] KeyBytes = 4'd8;

  typedef struct packed {
    logic op;
    logic line_level;
  } in_t;

  typedef struct packed {
    logic       drive_low;
    logic       busy_res;
    logic [1:0] status;
    logic [2:0] byte_index;
    logic [7:0] key_byte;
    logic       last;
  } out_t;

endpackage

>>> hw/rtl/one_wire_read_rom_master.sv
// Each accepted word's result word is loaded into the result register.
// Throughput: one word per cycle; the input takes a word whenever the result
// register is empty or its word is being taken in the same cycle.
// Reset (rst_ni low, asynchronous): sequencer idle, counters cleared,
// enabled cleared, no result pending.
// Top level: 1-Wire master that resets the bus, sends Read ROM and reads the key.
`timescale 1ns / 1ps
module one_wire_read_rom_master (
  input  logic              clk_i,
  input  logic              rst_ni,
  // input words
  input  logic              in_valid_i,
  output logic              in_ready_o,
  input  owrr_pkg::in_t     in_data_i,
  // result words
  output logic              out_valid_o,
  input  logic              out_ready_i,
  output owrr_pkg::out_t    out_data_o,
  // configuration port
  input  logic              psel,
  input  logic              penable,
  input  logic              pwrite,
  input  logic [2:0]        paddr,
  input  logic [31:0]       pwdata,
  output logic [31:0]       prdata,
  output logic              pready
);

  owrr_pkg::phase_e phase_q, phase_d;
  logic [8:0]       us_q, us_d;
  logic [2:0]       bit_q, bit_d;
  logic [2:0]       byte_q, byte_d;
  logic [7:0]       shift_q, shift_d;
  logic             pres_q, pres_d;
  logic             enabled_q;
  logic             out_valid_q;
  owrr_pkg::out_t   out_q, res_d;
  logic             in_fire;
  logic [8:0]       us_inc;
  logic             wbit;
  logic [3:0]       byte_next;

  // Configuration register
  assign pready = 1'b1;
  assign prdata = (paddr[2] == owrr_pkg::RegEnabled) ? {31'd0, enabled_q} : 32'd0;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      enabled_q <= 1'b0;
    end else if (psel && penable && pwrite && pready &&
                 (paddr[2] == owrr_pkg::RegEnabled)) begin
      enabled_q <= pwdata[0];
    end
  end

  // Accept a word when the result register frees up
  assign in_ready_o = !out_valid_q || out_ready_i;
  assign in_fire    = in_valid_i && in_ready_o;

  assign us_inc    = us_q + 9'd1;
  assign byte_next = {1'b0, byte_q} + 4'd1;

  // Next state and result word
  always_comb begin
    phase_d = phase_q;
    us_d    = us_q;
    bit_d   = bit_q;
    byte_d  = byte_q;
    shift_d = shift_q;
    pres_d  = pres_q;
    res_d   = '0;
    wbit    = owrr_pkg::RomCmd[bit_q];

    if (in_data_i.op == owrr_pkg::OpStart) begin
      if (phase_q != owrr_pkg::PH_IDLE) begin
        res_d.status = owrr_pkg::StRefused;
      end else if (!enabled_q) begin
        res_d.status = owrr_pkg::StRefused;
        res_d.last   = 1'b1;
      end else begin
        phase_d = owrr_pkg::PH_RST_LOW;
        us_d    = '0;
        bit_d   = '0;
        byte_d  = '0;
        shift_d = '0;
        pres_d  = 1'b0;
      end
    end else if (phase_q != owrr_pkg::PH_IDLE) begin
      us_d = us_inc;
      unique case (phase_q)
        owrr_pkg::PH_RST_LOW: begin
          if (us_inc >= owrr_pkg::RstLowUs) begin
            phase_d = owrr_pkg::PH_RST_WAIT;
            us_d    = '0;
          end
        end
        owrr_pkg::PH_RST_WAIT: begin
          // sample presence: a low line means a device answered
          if (us_inc >= owrr_pkg::PresSampleUs) begin
            pres_d  = !in_data_i.line_level;
            phase_d = owrr_pkg::PH_RST_REC;
            us_d    = '0;
          end
        end
        owrr_pkg::PH_RST_REC: begin
          if (us_inc >= owrr_pkg::RstRecUs) begin
            us_d = '0;
            if (!pres_q) begin
              phase_d      = owrr_pkg::PH_IDLE;
              res_d.status = owrr_pkg::StNoPresent;
              res_d.last   = 1'b1;
            end else begin
              phase_d = owrr_pkg::PH_WRITE;
              bit_d   = '0;
            end
          end
        end
        owrr_pkg::PH_WRITE: begin
          if (us_inc >= (wbit ? owrr_pkg::Wr1SlotUs : owrr_pkg::Wr0SlotUs)) begin
            us_d = '0;
            if (bit_q == 3'd7) begin
              phase_d = owrr_pkg::PH_READ;
              bit_d   = '0;
              byte_d  = '0;
              shift_d = '0;
            end else begin
              bit_d = bit_q + 3'd1;
            end
          end
        end
        owrr_pkg::PH_READ: begin
          // sample the data bit early in the slot, at RdSampleUs
          if (us_inc == owrr_pkg::RdSampleUs && in_data_i.line_level) begin
            shift_d[bit_q] = 1'b1;
          end
          if (us_inc >= owrr_pkg::RdSlotUs) begin
            us_d = '0;
            if (bit_q == 3'd7) begin
              res_d.status     = owrr_pkg::StKeyByte;
              res_d.byte_index = byte_q;
              res_d.key_byte   = shift_d;
              bit_d            = '0;
              shift_d          = '0;
              if (byte_next >= owrr_pkg::KeyBytes) begin
                res_d.last = 1'b1;
                phase_d    = owrr_pkg::PH_IDLE;
                byte_d     = '0;
              end else begin
                byte_d = byte_next[2:0];
              end
            end else begin
              bit_d = bit_q + 3'd1;
            end
          end
        end
        default: begin
          phase_d = owrr_pkg::PH_IDLE;
          us_d    = '0;
        end
      endcase
    end

    // Line drive for the coming microsecond
    unique case (phase_d)
      owrr_pkg::PH_RST_LOW: res_d.drive_low = 1'b1;
      owrr_pkg::PH_WRITE: begin
        res_d.drive_low = us_d < (owrr_pkg::RomCmd[bit_d] ? owrr_pkg::Wr1LowUs
                                                          : owrr_pkg::Wr0LowUs);
      end
      owrr_pkg::PH_READ: res_d.drive_low = us_d < owrr_pkg::RdLowUs;
      default:           res_d.drive_low = 1'b0;
    endcase
    res_d.busy_res = phase_d != owrr_pkg::PH_IDLE;
  end

  // Sequencer state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q <= owrr_pkg::PH_IDLE;
      us_q    <= '0;
      bit_q   <= '0;
      byte_q  <= '0;
      shift_q <= '0;
      pres_q  <= 1'b0;
    end else if (in_fire) begin
      phase_q <= phase_d;
      us_q    <= us_d;
      bit_q   <= bit_d;
      byte_q  <= byte_d;
      shift_q <= shift_d;
      pres_q  <= pres_d;
    end
  end

  // Result register valid
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (in_fire) begin
      out_valid_q <= 1'b1;
    end else if (out_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  // Result register payload
  always_ff @(posedge clk_i) begin
    if (in_fire) begin
      out_q <= res_d;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

endmodule
